// ===== sv/bdqs_pkg.sv =====
// Shared types, constants and helpers for the bounded deque with search.
package bdqs_pkg;

  localparam int DEPTH = 16;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam int VAL_W = 32;
  localparam int OP_W = 3;
  localparam int STAT_W = 2;
  localparam int POS_W = 4;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW = $clog2(CQ_DEPTH);
  localparam int CQ_CW = $clog2(CQ_DEPTH + 1);

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    K_PUSH_BACK,
    K_POP_FRONT,
    K_PUSH_FRONT,
    K_POP_BACK,
    K_SEARCH,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

  // Ring index a + b, with a < DEPTH and b <= DEPTH.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (a == '0) begin
      r = AW'(DEPTH - 1);
    end else begin
      r = a - AW'(1);
    end
    return r;
  endfunction

endpackage

// ===== sv/bdqs_front.sv =====
// Request intake: opcode decode and a short command queue toward the back end.
module bdqs_front
  import bdqs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic signed [VAL_W-1:0] operand_value_i,
  output logic                    busy_o,
  output logic                    cmd_valid_o,
  output cmd_t                    cmd_o,
  input  logic                    cmd_ready_i
);

  cmd_t             q_mem [CQ_DEPTH];
  logic [CQ_AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CQ_CW-1:0] cnt_q, cnt_d;
  logic             push, pop;
  cmd_t             cmd_in;

  always_comb begin
    cmd_in.value = operand_value_i;
    unique case (opcode_i)
      OP_PUSH_BACK:  cmd_in.kind = K_PUSH_BACK;
      OP_POP_FRONT:  cmd_in.kind = K_POP_FRONT;
      OP_PUSH_FRONT: cmd_in.kind = K_PUSH_FRONT;
      OP_POP_BACK:   cmd_in.kind = K_POP_BACK;
      OP_SEARCH:     cmd_in.kind = K_SEARCH;
      default:       cmd_in.kind = K_NOP;
    endcase
  end

  assign busy_o      = (cnt_q == CQ_CW'(CQ_DEPTH));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) begin
      wp_d = (wp_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wp_q + CQ_AW'(1);
    end
    if (pop) begin
      rp_d = (rp_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rp_q + CQ_AW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CQ_CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CQ_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= cmd_in;
    end
  end

endmodule

// ===== sv/bdqs_back.sv =====
// Execution engine: ring store, pointers, sequential search and result register.
module bdqs_back
  import bdqs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_ready_o,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic              found_o,
  output logic [POS_W-1:0]  found_position_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata_q;
  logic signed [VAL_W-1:0] key_q, key_d;

  logic          state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rk_q, rk_d;
  logic [AW-1:0] ck_q, ck_d;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;

  logic              done_q, done_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic              found_q, found_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW+POS_W-1:0] pos_ext;

  logic full, empty, last;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);
  assign last  = (CW'(ck_q) == count_q - CW'(1));
  assign cmd_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    count_d  = count_q;
    rk_d     = rk_q;
    ck_d     = ck_q;
    key_d    = key_q;
    wr_en    = 1'b0;
    wr_addr  = front_q;
    rd_addr  = wrap_add(front_q, rk_q);
    done_d   = 1'b0;
    status_d = ST_DONE;
    found_d  = 1'b0;
    pos_d    = '0;
    unique case (state_q)
      S_IDLE: begin
        rd_addr = front_q;
        if (cmd_valid_i) begin
          done_d = 1'b1;
          unique case (cmd_i.kind)
            K_PUSH_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = wrap_add(front_q, count_q);
                count_d = count_q + CW'(1);
              end
            end
            K_PUSH_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = wrap_dec(front_q);
                front_d = wrap_dec(front_q);
                count_d = count_q + CW'(1);
              end
            end
            K_POP_FRONT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                front_d = wrap_add(front_q, CW'(1));
                count_d = count_q - CW'(1);
              end
            end
            K_POP_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            K_SEARCH: begin
              if (!empty) begin
                done_d  = 1'b0;
                key_d   = cmd_i.value;
                rk_d    = CW'(1);
                ck_d    = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rdata_q == key_q) begin
          done_d  = 1'b1;
          found_d = 1'b1;
          pos_d   = ck_q;
          state_d = S_IDLE;
        end else if (last) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ck_d = AW'(rk_q);
          rk_d = rk_q + CW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
      rk_q    <= '0;
      ck_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      rk_q    <= rk_d;
      ck_q    <= ck_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    status_q <= status_d;
    found_q  <= found_d;
    pos_q    <= pos_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.value;
    end
    rdata_q <= mem[rd_addr];
  end

  assign pos_ext          = {{POS_W{1'b0}}, pos_q};
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign found_o          = found_q;
  assign found_position_o = pos_ext[POS_W-1:0];

endmodule

// ===== sv/bounded_deque_with_search_top.sv =====
// Top level of the bounded deque with linear search.
// Each request (start_i high while busy_o is low) yields exactly one result, shown for one
// cycle with done_o high; results cannot be held off, so capture them on that strobe.
// Requests enter a two-entry command queue, so up to two may be taken while the engine works.
// Push, pop and unused opcodes are handled by the engine in its idle state, and the result is
// registered after the command queue. A search reads the entry store one entry a cycle through
// its single read port, from the front: it compares at most count entries (at most DEPTH), fewer
// when a match is found early, and ends in the idle state without a scan on an empty queue.
module bounded_deque_with_search_top
  import bdqs_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic signed [VAL_W-1:0] operand_value_i,
  output logic                    done_o,
  output logic [STAT_W-1:0]       status_o,
  output logic                    found_o,
  output logic [POS_W-1:0]        found_position_o
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  bdqs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .opcode_i        (opcode_i),
    .operand_value_i (operand_value_i),
    .busy_o          (busy_o),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_ready_i     (cmd_ready)
  );

  bdqs_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_ready_o      (cmd_ready),
    .done_o           (done_o),
    .status_o         (status_o),
    .found_o          (found_o),
    .found_position_o (found_position_o)
  );

  a_req_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> cmd_valid)
    else $error("accepted request did not reach the command queue");

  a_short_cmd_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid && cmd_ready && (cmd.kind != K_SEARCH) |=> done_o)
    else $error("non-search command produced no result in the next cycle");

  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && found_o |-> status_o == ST_DONE)
    else $error("search hit reported with non-done status");

endmodule
